/* rtl/json_string_unescaper_top_macros.svh */
// Assertion macros for the unescaper RTL.
`ifndef JSON_STRING_UNESCAPER_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPER_TOP_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define JSU_ASSERT_RST(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked implication, masked while reset is asserted.
`define JSU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/jsu_pkg.sv */
// Shared types, character codes and decode helpers for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

	localparam int unsigned MAX_OUT = 6;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_U         = 8'h75;
	localparam logic [7:0] CH_BS_CTRL   = 8'h08;
	localparam logic [7:0] CH_FF_CTRL   = 8'h0C;
	localparam logic [7:0] CH_LF_CTRL   = 8'h0A;
	localparam logic [7:0] CH_CR_CTRL   = 8'h0D;
	localparam logic [7:0] CH_TAB_CTRL  = 8'h09;

	// Escape phase: plain text, backslash seen, or \u with 0..3 digits held
	typedef enum logic [2:0] {
		PH_PLAIN  = 3'd0,
		PH_BSLASH = 3'd1,
		PH_U0     = 3'd2,
		PH_U1     = 3'd3,
		PH_U2     = 3'd4,
		PH_U3     = 3'd5
	} phase_t;

	// One accepted byte's worth of output, up to six bytes
	typedef struct packed {
		logic                     last;
		logic [2:0]               count;
		logic [MAX_OUT-1:0][7:0]  bytes;
	} cmd_t;

	// Digit value in [3:0]; bit 4 set when the byte is not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'h10;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h37)};
		return r;
	endfunction

	// Single-character escape: bit 8 set when the byte names a known escape
	function automatic logic [8:0] esc_map(input logic [7:0] b);
		logic [8:0] r;
		unique case (b)
			CH_QUOTE:     r = {1'b1, CH_QUOTE};
			CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
			CH_SLASH:     r = {1'b1, CH_SLASH};
			CH_B:         r = {1'b1, CH_BS_CTRL};
			CH_F:         r = {1'b1, CH_FF_CTRL};
			CH_N:         r = {1'b1, CH_LF_CTRL};
			CH_R:         r = {1'b1, CH_CR_CTRL};
			CH_T:         r = {1'b1, CH_TAB_CTRL};
			default:      r = {1'b0, b};
		endcase
		return r;
	endfunction

	// Number of hex digits held in a \u phase
	function automatic logic [1:0] digits_held(input phase_t p);
		logic [1:0] r;
		unique case (p)
			PH_U1:   r = 2'd1;
			PH_U2:   r = 2'd2;
			PH_U3:   r = 2'd3;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/json_string_unescaper_top.sv */
// An accepted byte's command is written into the queue, then loaded into the output register.
// Throughput: one input beat per cycle while each byte yields at most one output byte;
// an escape flush yields up to six bytes, drained one per cycle while m_tready is high.
// A four-entry command queue lets the input run on while the output port stalls, until it fills.
// Reset (arst_n low, asynchronous): phase returns to plain text, queue and output empty.
`timescale 1ns / 1ps

module json_string_unescaper_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // end_of_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast    // last_of_string
);

	jsu_pkg::cmd_t push_cmd;
	jsu_pkg::cmd_t head_cmd;
	logic          push;
	logic          full;
	logic          pop;
	logic          head_valid;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.cmd_push (push),
		.cmd      (push_cmd),
		.q_full   (full)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_cmd     (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (head_valid),
		.q_cmd     (head_cmd),
		.q_pop     (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

/* rtl/jsu_front.sv */
// Front end: accepts raw bytes, tracks the escape phase and builds output commands.
`timescale 1ns / 1ps

module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              cmd_push,
	output jsu_pkg::cmd_t     cmd,
	input  logic              q_full
);

	jsu_pkg::phase_t phase_q, phase_d;
	logic [2:0][7:0] held_q;
	logic            accept;
	logic            held_we;
	logic [1:0]      held_idx;
	logic [4:0]      hv;
	logic [4:0]      hv_hi;
	logic [8:0]      esc;
	logic [1:0]      ndig;
	logic [2:0]      n_v;
	logic [jsu_pkg::MAX_OUT-1:0][7:0] bytes_v;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign hv       = jsu_pkg::hex_value(in_byte);
	assign hv_hi    = jsu_pkg::hex_value(held_q[2]);
	assign esc      = jsu_pkg::esc_map(in_byte);
	assign held_idx = jsu_pkg::digits_held(phase_q);

	// Hold the escape phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsu_pkg::PH_PLAIN;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	// Capture hex digits of a \u sequence
	always_ff @(posedge clk) begin
		if (accept && held_we) begin
			held_q[held_idx] <= in_byte;
		end
	end

	// Decide next phase and the bytes this beat gives
	always_comb begin
		phase_d = phase_q;
		held_we = 1'b0;
		n_v     = 3'd0;
		bytes_v = '0;
		ndig    = 2'd0;
		unique case (phase_q)
			jsu_pkg::PH_PLAIN: begin
				if (in_byte == jsu_pkg::CH_BACKSLASH) begin
					phase_d = jsu_pkg::PH_BSLASH;
				end else begin
					bytes_v[n_v] = in_byte;
					n_v = n_v + 3'd1;
				end
			end
			jsu_pkg::PH_BSLASH: begin
				phase_d = jsu_pkg::PH_PLAIN;
				if (in_byte == jsu_pkg::CH_U) begin
					phase_d = jsu_pkg::PH_U0;
				end else if (esc[8]) begin
					bytes_v[n_v] = esc[7:0];
					n_v = n_v + 3'd1;
				end else begin
					bytes_v[n_v] = jsu_pkg::CH_BACKSLASH;
					n_v = n_v + 3'd1;
					bytes_v[n_v] = in_byte;
					n_v = n_v + 3'd1;
				end
			end
			jsu_pkg::PH_U0, jsu_pkg::PH_U1, jsu_pkg::PH_U2, jsu_pkg::PH_U3: begin
				if (hv[4]) begin
					// Bad digit: flush the sequence, then treat the byte as plain
					ndig = jsu_pkg::digits_held(phase_q);
					bytes_v[n_v] = jsu_pkg::CH_BACKSLASH;
					n_v = n_v + 3'd1;
					bytes_v[n_v] = jsu_pkg::CH_U;
					n_v = n_v + 3'd1;
					for (int k = 0; k < 3; k++) begin
						if (2'(k) < ndig) begin
							bytes_v[n_v] = held_q[k];
							n_v = n_v + 3'd1;
						end
					end
					if (in_byte == jsu_pkg::CH_BACKSLASH) begin
						phase_d = jsu_pkg::PH_BSLASH;
					end else begin
						phase_d = jsu_pkg::PH_PLAIN;
						bytes_v[n_v] = in_byte;
						n_v = n_v + 3'd1;
					end
				end else if (phase_q == jsu_pkg::PH_U3) begin
					// Fourth digit: emit the low byte of the code point
					bytes_v[n_v] = {hv_hi[3:0], hv[3:0]};
					n_v = n_v + 3'd1;
					phase_d = jsu_pkg::PH_PLAIN;
				end else begin
					held_we = 1'b1;
					phase_d = jsu_pkg::phase_t'(phase_q + 3'd1);
				end
			end
			default: begin
				phase_d = jsu_pkg::PH_PLAIN;
			end
		endcase

		// End of string: flush whatever is pending
		if (in_last && phase_d != jsu_pkg::PH_PLAIN) begin
			ndig = jsu_pkg::digits_held(phase_d);
			bytes_v[n_v] = jsu_pkg::CH_BACKSLASH;
			n_v = n_v + 3'd1;
			if (phase_d != jsu_pkg::PH_BSLASH) begin
				bytes_v[n_v] = jsu_pkg::CH_U;
				n_v = n_v + 3'd1;
				for (int k = 0; k < 3; k++) begin
					if (2'(k) < ndig) begin
						// The digit taken on this beat is not in held_q yet
						bytes_v[n_v] = (held_we && 2'(k) == held_idx) ? in_byte
							: held_q[k];
						n_v = n_v + 3'd1;
					end
				end
			end
			phase_d = jsu_pkg::PH_PLAIN;
		end
	end

	assign cmd_push  = accept && (n_v != 3'd0);
	assign cmd.last  = in_last;
	assign cmd.count = n_v;
	assign cmd.bytes = bytes_v;

endmodule

/* rtl/jsu_queue.sv */
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module jsu_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output jsu_pkg::cmd_t head_cmd
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	jsu_pkg::cmd_t   mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign full       = (cnt_q == FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/jsu_back.sv */
// Back end: expands queued commands into output beats through an output register.
`timescale 1ns / 1ps
`include "json_string_unescaper_top_macros.svh"

module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  jsu_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_last
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [2:0] idx_q;
	logic       load;
	logic       final_byte;

	assign load       = !valid_q || out_ready;
	assign final_byte = (idx_q == q_cmd.count - 3'd1);
	assign q_pop      = load && q_valid && final_byte;

	// Step through the head command one byte per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= q_valid;
			if (q_valid) begin
				idx_q <= final_byte ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	// Load the output byte
	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			byte_q <= q_cmd.bytes[idx_q];
			last_q <= q_cmd.last && final_byte;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	`JSU_ASSERT_IMP(a_cmd_nonempty, clk, arst_n, q_valid, q_cmd.count != 3'd0, "empty command queued")
	`JSU_ASSERT_IMP(a_cmd_bound, clk, arst_n, q_valid, q_cmd.count <= 3'd6, "command too long")
	`JSU_ASSERT_IMP(a_idx_head, clk, arst_n, idx_q != 3'd0, q_valid, "partial command lost")
	`JSU_ASSERT_IMP(a_idx_range, clk, arst_n, q_valid && idx_q != 3'd0, idx_q < q_cmd.count, "index past command")

endmodule

/* dv/json_string_unescaper_checker.sv */
// Scoreboard for the JSON string unescaper: predicts output beats and compares them.
`timescale 1ns / 1ps

module jsu_unescape_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_string
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [7:0] out_byte
	input  logic        m_tlast,   // last_of_string
	output int unsigned fault_count,
	output int unsigned beats_owed
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} text_beat_t;

	// Shadow decoder state
	jsu_pkg::phase_t esc_phase;
	logic [7:0]      held_digits [3];

	// Bytes decoded from the current input beat, then the beats still owed by the block
	logic [7:0] decoded [$];
	text_beat_t owed_q [$];

	initial begin
		esc_phase   = jsu_pkg::PH_PLAIN;
		fault_count = 0;
	end

	// Append one byte to this beat's decoded bytes
	function automatic void add_byte(input logic [7:0] b);
		decoded.insert(decoded.size(), b);
	endfunction

	// Digit value in [3:0], bit 4 raised for anything that is not a hex digit
	function automatic logic [4:0] nibble_of(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39)
			return {1'b0, b[3:0]};
		if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
			return {1'b0, b[3:0] + 4'd9};
		return 5'h10;
	endfunction

	// A byte seen as ordinary text: a backslash opens an escape, anything else passes
	function automatic void take_text(input logic [7:0] b);
		if (b == jsu_pkg::CH_BACKSLASH)
			esc_phase = jsu_pkg::PH_BSLASH;
		else
			add_byte(b);
	endfunction

	// Give back a pending backslash, u and held digits untouched
	function automatic void spill_escape();
		int held;
		if (esc_phase == jsu_pkg::PH_PLAIN)
			return;
		add_byte(jsu_pkg::CH_BACKSLASH);
		if (esc_phase != jsu_pkg::PH_BSLASH) begin
			add_byte(jsu_pkg::CH_U);
			held = int'(esc_phase) - int'(jsu_pkg::PH_U0);
			for (int k = 0; k < held; k++)
				add_byte(held_digits[k]);
		end
		esc_phase = jsu_pkg::PH_PLAIN;
	endfunction

	// Work out the output beats caused by one input beat and queue them
	function automatic void unescape_beat(input logic [7:0] b, input logic eos);
		logic [4:0] nib;
		logic [4:0] high_nib;
		decoded.delete();
		nib = nibble_of(b);
		case (esc_phase)
			jsu_pkg::PH_PLAIN: begin
				take_text(b);
			end
			jsu_pkg::PH_BSLASH: begin
				esc_phase = jsu_pkg::PH_PLAIN;
				case (b)
					jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: add_byte(b);
					jsu_pkg::CH_B: add_byte(jsu_pkg::CH_BS_CTRL);
					jsu_pkg::CH_F: add_byte(jsu_pkg::CH_FF_CTRL);
					jsu_pkg::CH_N: add_byte(jsu_pkg::CH_LF_CTRL);
					jsu_pkg::CH_R: add_byte(jsu_pkg::CH_CR_CTRL);
					jsu_pkg::CH_T: add_byte(jsu_pkg::CH_TAB_CTRL);
					jsu_pkg::CH_U: esc_phase = jsu_pkg::PH_U0;
					default: begin
						add_byte(jsu_pkg::CH_BACKSLASH);
						add_byte(b);
					end
				endcase
			end
			default: begin
				if (nib[4]) begin
					// not a hex digit: spill the escape, then treat the byte as text
					spill_escape();
					take_text(b);
				end else if (esc_phase == jsu_pkg::PH_U3) begin
					// fourth digit: keep only the low byte of the code point
					high_nib = nibble_of(held_digits[2]);
					add_byte({high_nib[3:0], nib[3:0]});
					esc_phase = jsu_pkg::PH_PLAIN;
				end else begin
					held_digits[int'(esc_phase) - int'(jsu_pkg::PH_U0)] = b;
					esc_phase = jsu_pkg::phase_t'(esc_phase + 3'd1);
				end
			end
		endcase
		if (eos)
			spill_escape();
		foreach (decoded[i])
			owed_q.insert(owed_q.size(),
				'{data: decoded[i], last: eos && (i == decoded.size() - 1)});
	endfunction

	// Predict on each accepted input beat, compare each accepted output beat
	always @(posedge clk) begin
		text_beat_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				unescape_beat(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (owed_q.size() == 0) begin
					if (fault_count < 10)
						$display("%0t: unexpected beat data=%02h last=%b",
							$realtime, m_tdata, m_tlast);
					fault_count++;
				end else begin
					want = owed_q.pop_front();
					if (m_tdata !== want.data || m_tlast !== want.last) begin
						if (fault_count < 10)
							$display("%0t: beat mismatch: expected data=%02h last=%b, got data=%02h last=%b",
								$realtime, want.data, want.last, m_tdata, m_tlast);
						fault_count++;
					end
				end
			end
			beats_owed <= owed_q.size();
		end
	end

endmodule

/* dv/tb_json_string_unescaper_top.sv */
// Testbench top for the JSON string unescaper: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_json_string_unescaper_top;

	localparam int unsigned RUN_ITEMS   = 210;
	localparam int unsigned QUIET_ITEMS = 175;
	localparam int unsigned LONG_HOLD   = 80;
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] in_byte
	logic       s_tlast;   // end_of_string
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] out_byte
	logic       m_tlast;   // last_of_string

	int unsigned fault_count;
	int unsigned beats_owed;
	int unsigned cycle_count;
	int unsigned bytes_sent;

	bit sender_gaps;
	bit receiver_gaps;
	bit long_hold_req;

	// Letters that complete a single-character escape
	logic [7:0] esc_letters [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH,
		jsu_pkg::CH_SLASH, jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
		jsu_pkg::CH_R, jsu_pkg::CH_T};

	json_string_unescaper_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	jsu_unescape_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.fault_count (fault_count),
		.beats_owed  (beats_owed)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_json_string_unescaper_top: done, errors");
			$finish;
		end
	end

	// Random hex digit character, upper or lower case
	function automatic logic [7:0] random_hex_char();
		logic [3:0] v;
		v = 4'($urandom_range(0, 15));
		if (v < 4'd10)
			return 8'h30 + 8'(v);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 4'd10);
	endfunction

	// Offer one beat, with an optional gap first, and hold it until taken
	task automatic send_beat(input logic [7:0] b, input logic eos);
		if (sender_gaps && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// One piece of string: text, escape, \u sequence or a broken one, maybe ending the string
	task automatic send_piece();
		logic [7:0] piece [$];
		int pick;
		int cut;
		logic eos;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			piece.insert(piece.size(), 8'($urandom_range(0, 255)));
		end else if (pick < 50) begin
			piece.insert(piece.size(), jsu_pkg::CH_BACKSLASH);
			piece.insert(piece.size(), esc_letters[$urandom_range(0, 7)]);
		end else if (pick < 75) begin
			piece.insert(piece.size(), jsu_pkg::CH_BACKSLASH);
			piece.insert(piece.size(), jsu_pkg::CH_U);
			repeat (4) piece.insert(piece.size(), random_hex_char());
		end else if (pick < 88) begin
			// truncated \u: some digits, then whatever byte comes along
			piece.insert(piece.size(), jsu_pkg::CH_BACKSLASH);
			piece.insert(piece.size(), jsu_pkg::CH_U);
			repeat ($urandom_range(0, 3)) piece.insert(piece.size(), random_hex_char());
			piece.insert(piece.size(), 8'($urandom_range(0, 255)));
		end else begin
			piece.insert(piece.size(), jsu_pkg::CH_BACKSLASH);
			piece.insert(piece.size(), 8'($urandom_range(0, 255)));
		end
		eos = ($urandom_range(0, 7) == 0);
		cut = piece.size();
		// now and then end the string part way through the piece
		if (eos && $urandom_range(0, 2) == 0)
			cut = $urandom_range(1, piece.size());
		for (int i = 0; i < cut; i++)
			send_beat(piece[i], eos && (i == cut - 1));
	endtask

	// Receiver: random stalls, and one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (receiver_gaps && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n        <= 1'b0;
		s_tvalid      <= 1'b0;
		s_tdata       <= 8'h00;
		s_tlast       <= 1'b0;
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		long_hold_req = 1'b0;
		bytes_sent    = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every single-character escape
		foreach (esc_letters[i]) begin
			send_beat(jsu_pkg::CH_BACKSLASH, 1'b0);
			send_beat(esc_letters[i], 1'b0);
		end
		// unknown escape on the top byte value, closing the string
		send_beat(jsu_pkg::CH_BACKSLASH, 1'b0);
		send_beat(8'hFF, 1'b1);
		// bad hex digit straight after \u; the zero byte then passes as text
		send_beat(jsu_pkg::CH_BACKSLASH, 1'b0);
		send_beat(jsu_pkg::CH_U, 1'b0);
		send_beat(8'h00, 1'b0);
		// string ends with three digits held: flush them
		send_beat(jsu_pkg::CH_BACKSLASH, 1'b0);
		send_beat(jsu_pkg::CH_U, 1'b0);
		send_beat(8'h31, 1'b0);
		send_beat(8'h32, 1'b0);
		send_beat(8'h43, 1'b1);
		// mixed-case \u sequence completed on the final byte
		send_beat(jsu_pkg::CH_BACKSLASH, 1'b0);
		send_beat(jsu_pkg::CH_U, 1'b0);
		send_beat(8'h61, 1'b0);
		send_beat(8'h42, 1'b0);
		send_beat(8'h33, 1'b0);
		send_beat(8'h66, 1'b1);

		// random strings, with a long output hold-off near the start
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		long_hold_req = 1'b1;
		while (bytes_sent < RUN_ITEMS) begin
			if (bytes_sent > QUIET_ITEMS) begin
				sender_gaps   = 1'b0;
				receiver_gaps = 1'b0;
			end
			send_piece();
		end
		s_tvalid <= 1'b0;

		// drain, then wait on for any stray beats
		do @(negedge clk); while (beats_owed != 0);
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("tb_json_string_unescaper_top: done, clean");
		else
			$display("tb_json_string_unescaper_top: done, errors");
		$finish;
	end

endmodule
